FILE: rtl/core/cdg_pkg.sv
// ---------------------------------------------------------------------------
// cdg_pkg
// Shared types and constants for the CD+G graphics packet decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cdg_pkg;

  // Default frame geometry
  localparam int FRAME_WIDTH_DEF  = 300;
  localparam int FRAME_HEIGHT_DEF = 216;

  // Tile geometry: one memory word holds one six-pixel tile row
  localparam int TILE_W = 6;
  localparam int TILE_H = 12;
  localparam int PIX_W  = 4;
  localparam int WORD_W = TILE_W * PIX_W;

  // Column divide by six through a reciprocal, exact for 9-bit columns
  localparam int DIV6_MUL   = 171;
  localparam int DIV6_SHIFT = 10;

  // Payload length that a tile or palette load needs
  localparam logic [4:0] PAYLOAD_FULL = 5'd16;

  // Operation codes
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Instruction codes
  localparam logic [2:0] INSTR_PRESET      = 3'd0;
  localparam logic [2:0] INSTR_BORDER      = 3'd1;
  localparam logic [2:0] INSTR_TILE        = 3'd2;
  localparam logic [2:0] INSTR_CLUT_LOW    = 3'd3;
  localparam logic [2:0] INSTR_CLUT_HIGH   = 3'd4;
  localparam logic [2:0] INSTR_TRANSPARENT = 3'd5;

  // Work class of a captured request
  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_APPLY = 3'd1,
    KIND_FILL  = 3'd2,
    KIND_TILE  = 3'd3,
    KIND_READ  = 3'd4
  } kind_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic fill_init;
    logic sweep_step;
    logic tile_init;
    logic tile_step;
    logic rd_div;
    logic rd_addr;
    logic rd_mem;
    logic apply;
    logic load_result;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    kind_t kind;
    logic  sweep_last;
    logic  tile_last;
    logic  out_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/cdg_ctrl.sv
// ---------------------------------------------------------------------------
// cdg_ctrl
// Sequencer: frame clear after reset, request decode, apply, fill, tile and read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdg_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output cdg_pkg::ctl_cmd_t     cmd,
  input  wire cdg_pkg::dp_sts_t sts
);
  import cdg_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_DECODE  = 8'b0000_0100,
    S_FILL    = 8'b0000_1000,
    S_TILE    = 8'b0001_0000,
    S_RD_ADDR = 8'b0010_0000,
    S_RD_MEM  = 8'b0100_0000,
    S_FINISH  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.kind)
          KIND_FILL: begin
            cmd.fill_init = 1'b1;
            state_nxt     = S_FILL;
          end
          KIND_TILE: begin
            cmd.tile_init = 1'b1;
            state_nxt     = S_TILE;
          end
          KIND_READ: begin
            cmd.rd_div = 1'b1;
            state_nxt  = S_RD_ADDR;
          end
          KIND_APPLY: begin
            cmd.apply = 1'b1;
            state_nxt = S_FINISH;
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_FILL: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_TILE: begin
        cmd.tile_step = 1'b1;
        if (sts.tile_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_RD_ADDR: begin
        cmd.rd_addr = 1'b1;
        state_nxt   = S_RD_MEM;
      end
      S_RD_MEM: begin
        cmd.rd_mem = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        // hold until the result register can take the new result
        if (!sts.out_busy) begin
          cmd.load_result = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DECODE))
    else $error("accepted request did not enter decode");

  a_fill_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL && !sts.sweep_last) |=> (state_r == S_FILL))
    else $error("frame fill left before its last word");

  a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && sts.out_busy) |=> (state_r == S_FINISH))
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire

FILE: rtl/core/cdg_datapath.sv
// ---------------------------------------------------------------------------
// cdg_datapath
// Frame memory, palette, index registers, address math and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdg_datapath #(
  parameter int FRAME_WIDTH  = cdg_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = cdg_pkg::FRAME_HEIGHT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cdg_pkg::ctl_cmd_t cmd,
  output cdg_pkg::dp_sts_t       sts,
  input  wire logic              in_operation,
  input  wire logic [2:0]        in_instruction_code,
  input  wire logic [63:0]       in_payload_low,
  input  wire logic [63:0]       in_payload_high,
  input  wire logic [4:0]        in_payload_length,
  input  wire logic [8:0]        in_pixel_x,
  input  wire logic [7:0]        in_pixel_y,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [23:0]            out_pixel_color,
  output logic [3:0]             out_border_index,
  output logic [3:0]             out_transparent_index
);
  import cdg_pkg::*;

  localparam int         GROUPS   = (FRAME_WIDTH + TILE_W - 1) / TILE_W;
  localparam int         DEPTH    = FRAME_HEIGHT * GROUPS;
  localparam int         ADDR_W   = $clog2(DEPTH);
  localparam logic [8:0] WIDTH_9  = 9'(FRAME_WIDTH);
  localparam logic [8:0] HEIGHT_9 = 9'(FRAME_HEIGHT);
  localparam logic [6:0] GROUPS_7 = 7'(GROUPS);

  // Captured request
  logic             op_r;
  logic [2:0]       code_r;
  logic [15:0][7:0] pay_r;
  logic [4:0]       len_r;
  logic [8:0]       x_r;
  logic [7:0]       y_r;

  // Index registers and palette
  logic [3:0]  border_r;
  logic [3:0]  trans_r;
  logic [23:0] clut_r [16];

  // Frame memory, one word per six-pixel group
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] mem_rd_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  // Sweep and tile state
  logic [3:0]        fill_val_r;
  logic [ADDR_W-1:0] sweep_r;
  logic [3:0]        tile_row_r;
  logic [8:0]        tile_py_r;
  logic [5:0]        tile_col;
  logic              tile_on_frame;
  logic [ADDR_W-1:0] tile_addr;
  logic [3:0]        tile_byte_idx;
  logic [7:0]        tile_bits;
  logic [5:0][3:0]   tile_word;

  // Read path
  logic [17:0]       div_prod;
  logic [6:0]        q_r;
  logic              in_range_r;
  logic [2:0]        rem_r;
  logic [ADDR_W-1:0] rd_addr_r;
  logic [5:0][3:0]   rd_word;
  logic [3:0]        rd_nib;

  // Result register
  logic        out_valid_r;
  logic [23:0] out_color_r;
  logic [3:0]  out_border_r;
  logic [3:0]  out_trans_r;

  kind_t kind;

  function automatic logic [23:0] clut_entry(input logic [7:0] hi, input logic [7:0] lo);
    logic [3:0] red;
    logic [3:0] green;
    logic [3:0] blue;
    red   = hi[5:2];
    green = {hi[1:0], lo[5:4]};
    blue  = lo[3:0];
    // widening by 17 repeats the nibble
    return {red, red, green, green, blue, blue};
  endfunction

  // Classify the captured request
  always_comb begin
    kind = KIND_NONE;
    if (op_r == OP_READ) begin
      kind = KIND_READ;
    end else begin
      unique case (code_r)
        INSTR_PRESET:      kind = (len_r != 5'd0) ? KIND_FILL : KIND_NONE;
        INSTR_TILE:        kind = (len_r >= PAYLOAD_FULL) ? KIND_TILE : KIND_NONE;
        INSTR_BORDER,
        INSTR_TRANSPARENT: kind = (len_r != 5'd0) ? KIND_APPLY : KIND_NONE;
        INSTR_CLUT_LOW,
        INSTR_CLUT_HIGH:   kind = (len_r >= PAYLOAD_FULL) ? KIND_APPLY : KIND_NONE;
        default:           kind = KIND_NONE;
      endcase
    end
  end

  assign sts.kind       = kind;
  assign sts.sweep_last = (sweep_r == ADDR_W'(DEPTH - 1));
  assign sts.tile_last  = (tile_row_r == 4'(TILE_H - 1));
  assign sts.out_busy   = out_valid_r && out_stall;

  // Tile row write
  assign tile_col      = pay_r[3][5:0];
  assign tile_on_frame = (tile_py_r < HEIGHT_9) && ({1'b0, tile_col} < GROUPS_7);
  assign tile_addr     = ADDR_W'(32'(tile_py_r) * GROUPS + 32'(tile_col));
  assign tile_byte_idx = tile_row_r + 4'd4;
  assign tile_bits     = pay_r[tile_byte_idx];

  always_comb begin
    for (int c = 0; c < TILE_W; c++) begin
      tile_word[c] = tile_bits[TILE_W - 1 - c] ? pay_r[1][3:0] : pay_r[0][3:0];
    end
  end

  assign mem_we    = cmd.sweep_step || (cmd.tile_step && tile_on_frame);
  assign mem_waddr = cmd.sweep_step ? sweep_r : tile_addr;
  assign mem_wdata = cmd.sweep_step ? {TILE_W{fill_val_r}} : tile_word;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_mem) begin
      mem_rd_r <= mem[rd_addr_r];
    end
  end

  // Read address: column split into group and pixel within group
  assign div_prod = 18'(x_r) * 18'(DIV6_MUL);
  assign rd_word  = mem_rd_r;
  assign rd_nib   = rd_word[rem_r];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_operation;
      code_r <= in_instruction_code;
      pay_r  <= {in_payload_high, in_payload_low};
      len_r  <= in_payload_length;
      x_r    <= in_pixel_x;
      y_r    <= in_pixel_y;
    end
    if (cmd.rd_div) begin
      q_r        <= 7'(div_prod >> DIV6_SHIFT);
      in_range_r <= (x_r < WIDTH_9) && ({1'b0, y_r} < HEIGHT_9);
    end
    if (cmd.rd_addr) begin
      rem_r     <= 3'(x_r - ({2'b0, q_r} * 9'(TILE_W)));
      rd_addr_r <= in_range_r ? ADDR_W'(32'(y_r) * GROUPS + 32'(q_r)) : '0;
    end
    if (cmd.tile_init) begin
      tile_py_r <= 9'(pay_r[2][4:0]) * 9'(TILE_H);
    end else if (cmd.tile_step) begin
      tile_py_r <= tile_py_r + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      border_r    <= '0;
      trans_r     <= '0;
      fill_val_r  <= '0;
      sweep_r     <= '0;
      tile_row_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        clut_r[i] <= '0;
      end
    end else begin
      if (cmd.fill_init) begin
        fill_val_r <= pay_r[0][3:0];
      end
      if (cmd.sweep_step) begin
        sweep_r <= sts.sweep_last ? '0 : sweep_r + ADDR_W'(1);
      end
      if (cmd.tile_init) begin
        tile_row_r <= '0;
      end else if (cmd.tile_step) begin
        tile_row_r <= sts.tile_last ? '0 : tile_row_r + 4'd1;
      end
      if (cmd.apply) begin
        unique case (code_r)
          INSTR_BORDER:      border_r <= pay_r[0][3:0];
          INSTR_TRANSPARENT: trans_r  <= pay_r[0][3:0];
          INSTR_CLUT_LOW: begin
            for (int i = 0; i < 8; i++) begin
              clut_r[i] <= clut_entry(pay_r[2*i], pay_r[2*i+1]);
            end
          end
          INSTR_CLUT_HIGH: begin
            for (int i = 0; i < 8; i++) begin
              clut_r[i+8] <= clut_entry(pay_r[2*i], pay_r[2*i+1]);
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.load_result) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_color_r  <= (op_r == OP_READ && in_range_r) ? clut_r[rd_nib] : 24'd0;
      out_border_r <= border_r;
      out_trans_r  <= trans_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_pixel_color       = out_color_r;
  assign out_border_index      = out_border_r;
  assign out_transparent_index = out_trans_r;

  a_waddr_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (32'(mem_waddr) < DEPTH))
    else $error("frame memory write outside the frame");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.load_result))
    else $error("result appeared without a load");

  a_tile_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tile_step |-> (tile_row_r < 4'(TILE_H)))
    else $error("tile row counter out of range");

endmodule

`default_nettype wire

FILE: rtl/core/cdg_graphics_packet_decoder.sv
// ---------------------------------------------------------------------------
// cdg_graphics_packet_decoder
// Requests are handled one at a time: the input stalls from accept until the
// result is loaded into the result register, so an output stall also holds
// off the next request. A pixel read steps through decode, column divide,
// address and memory read; fill and tile time is set by the frame memory's
// single write port (one six-pixel word per cycle).
// Reset: synchronous; indices and palette clear at once, then the frame is
// swept to zero with input stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdg_graphics_packet_decoder #(
  parameter int FRAME_WIDTH  = cdg_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = cdg_pkg::FRAME_HEIGHT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic [2:0]  in_instruction_code,
  input  wire logic [63:0] in_payload_low,
  input  wire logic [63:0] in_payload_high,
  input  wire logic [4:0]  in_payload_length,
  input  wire logic [8:0]  in_pixel_x,
  input  wire logic [7:0]  in_pixel_y,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [23:0]      out_pixel_color,
  output logic [3:0]       out_border_index,
  output logic [3:0]       out_transparent_index
);
  import cdg_pkg::*;

  // The frame is held as one memory word per six-pixel group of a row, so a
  // tile row lands in a single write and a preset sweeps one group per cycle.
  // Pixels past the right edge of a partial last group are written but never
  // read back, since reads beyond the frame width return color zero.

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // Sequencer: owns the request handshake and steps the datapath
  cdg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Datapath: capture, frame memory, palette, and result register
  cdg_datapath #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_operation          (in_operation),
    .in_instruction_code   (in_instruction_code),
    .in_payload_low        (in_payload_low),
    .in_payload_high       (in_payload_high),
    .in_payload_length     (in_payload_length),
    .in_pixel_x            (in_pixel_x),
    .in_pixel_y            (in_pixel_y),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_pixel_color       (out_pixel_color),
    .out_border_index      (out_border_index),
    .out_transparent_index (out_transparent_index)
  );

endmodule

`default_nettype wire

FILE: test/cdg_graphics_packet_decoder_tb.sv
// ---------------------------------------------------------------------------
// cdg_graphics_packet_decoder_tb
// Self-checking bench for the CD+G packet decoder. A behavioral copy of the
// frame, palette and index registers predicts one result per request. Directed
// tests cover reset state, palette loads, presets, index registers, short and
// ignored packets and tiles at the frame edge. Random traffic with idle bursts
// on both sides follows, then a tail with no idling at all.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdg_graphics_packet_decoder_tb;
  import cdg_pkg::*;

  localparam int FRAME_W      = FRAME_WIDTH_DEF;
  localparam int FRAME_H      = FRAME_HEIGHT_DEF;
  localparam int FRAME_PIXELS = FRAME_W * FRAME_H;
  // Tile rows and columns that land inside the frame
  localparam int TILE_ROWS_IN = FRAME_H / TILE_H;
  localparam int TILE_COLS_IN = FRAME_W / TILE_W;

  // Instruction codes the block decodes as no-ops
  localparam logic [2:0] INSTR_SPARE_6 = 3'd6;
  localparam logic [2:0] INSTR_SPARE_7 = 3'd7;

  // 4-bit channel to 8-bit channel
  localparam logic [7:0] CHAN_SCALE = 8'd17;

  // A memory preset keeps both channels quiet for a whole frame sweep, and so
  // does the clearing sweep after reset; allow several times that.
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_ITEMS   = 1300;
  localparam int TAIL_ITEMS     = 220;
  localparam int RANDOM_PRESETS = 10;

  typedef struct {
    logic        op;
    logic [2:0]  code;
    logic [63:0] pay_lo;
    logic [63:0] pay_hi;
    logic [4:0]  len;
    logic [8:0]  x;
    logic [7:0]  y;
  } request_t;

  typedef struct {
    logic [23:0] color;
    logic [3:0]  border;
    logic [3:0]  transp;
  } pixel_result_t;

  // -------------------------------------------------------------------------
  // Clock, reset and DUT ports; every input starts at a known value
  // -------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_operation = OP_PACKET;
  logic [2:0]  in_instruction_code = INSTR_PRESET;
  logic [63:0] in_payload_low = '0;
  logic [63:0] in_payload_high = '0;
  logic [4:0]  in_payload_length = '0;
  logic [8:0]  in_pixel_x = '0;
  logic [7:0]  in_pixel_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [23:0] out_pixel_color;
  logic [3:0]  out_border_index;
  logic [3:0]  out_transparent_index;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cdg_graphics_packet_decoder DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_operation         (in_operation),
    .in_instruction_code  (in_instruction_code),
    .in_payload_low       (in_payload_low),
    .in_payload_high      (in_payload_high),
    .in_payload_length    (in_payload_length),
    .in_pixel_x           (in_pixel_x),
    .in_pixel_y           (in_pixel_y),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_pixel_color      (out_pixel_color),
    .out_border_index     (out_border_index),
    .out_transparent_index(out_transparent_index)
  );

  // -------------------------------------------------------------------------
  // Shadow copy of the decoder state and the queue of predicted results
  // -------------------------------------------------------------------------
  logic [3:0]    frame_idx [FRAME_PIXELS];
  logic [23:0]   palette [16];
  logic [3:0]    border_idx;
  logic [3:0]    transp_idx;
  pixel_result_t pending_results [$];

  int  fail_count = 0;
  int  results_seen = 0;
  int  quiet_cycles = 0;
  int  stall_left = 0;
  bit  stall_on = 1'b0;
  bit  sender_gaps = 1'b0;

  function automatic logic [7:0] pay_byte(input request_t r, input int k);
    logic [127:0] all;
    all = {r.pay_hi, r.pay_lo};
    return all[8*k +: 8];
  endfunction

  task automatic clear_shadow();
    foreach (frame_idx[i]) frame_idx[i] = '0;
    foreach (palette[i]) palette[i] = '0;
    border_idx = '0;
    transp_idx = '0;
  endtask

  // Eight palette entries from sixteen bytes: high byte carries R and the
  // upper half of G, low byte the lower half of G and B.
  task automatic load_palette(input request_t r, input int base);
    logic [7:0] hi6, lo6;
    logic [3:0] red, green, blue;
    for (int i = 0; i < 8; i++) begin
      hi6   = pay_byte(r, 2*i) & 8'h3F;
      lo6   = pay_byte(r, 2*i + 1) & 8'h3F;
      red   = hi6[5:2];
      green = {hi6[1:0], lo6[5:4]};
      blue  = lo6[3:0];
      palette[base + i] = {red * CHAN_SCALE, green * CHAN_SCALE, blue * CHAN_SCALE};
    end
  endtask

  // Apply one request to the shadow state and return its result
  task automatic decode_request(input request_t r, output pixel_result_t res);
    int         len, top, left, py, px;
    logic [7:0] b0, bits;
    logic [3:0] c0, c1;
    len = (r.len > PAYLOAD_FULL) ? int'(PAYLOAD_FULL) : int'(r.len);
    b0  = pay_byte(r, 0);
    c0  = b0[3:0];
    bits = pay_byte(r, 1);
    c1  = bits[3:0];
    res.color = '0;
    if (r.op == OP_PACKET) begin
      case (r.code)
        INSTR_PRESET: if (len >= 1) foreach (frame_idx[i]) frame_idx[i] = c0;
        INSTR_BORDER: if (len >= 1) border_idx = c0;
        INSTR_TRANSPARENT: if (len >= 1) transp_idx = c0;
        INSTR_CLUT_LOW: if (len >= PAYLOAD_FULL) load_palette(r, 0);
        INSTR_CLUT_HIGH: if (len >= PAYLOAD_FULL) load_palette(r, 8);
        INSTR_TILE: if (len >= PAYLOAD_FULL) begin
          top  = (pay_byte(r, 2) & 8'h1F) * TILE_H;
          left = (pay_byte(r, 3) & 8'h3F) * TILE_W;
          for (int row = 0; row < TILE_H; row++) begin
            bits = pay_byte(r, 4 + row);
            py   = top + row;
            for (int col = 0; col < TILE_W; col++) begin
              px = left + col;
              // clip at the frame edge, paint the rest
              if (py < FRAME_H && px < FRAME_W)
                frame_idx[py*FRAME_W + px] = bits[TILE_W-1-col] ? c1 : c0;
            end
          end
        end
        default: ;
      endcase
    end else if (r.x < FRAME_W && r.y < FRAME_H) begin
      res.color = palette[frame_idx[r.y*FRAME_W + r.x]];
    end
    res.border = border_idx;
    res.transp = transp_idx;
  endtask

  // -------------------------------------------------------------------------
  // Request drivers; drive at the falling edge, sample at the rising edge
  // -------------------------------------------------------------------------

  // Drive one request and hold it until accepted. Valid stays high on return;
  // the next send, hold_off or drain_results decides it at the next falling edge.
  task automatic send_request(input request_t r);
    pixel_result_t exp_res;
    @(negedge clk);
    in_valid            <= 1'b1;
    in_operation        <= r.op;
    in_instruction_code <= r.code;
    in_payload_low      <= r.pay_lo;
    in_payload_high     <= r.pay_hi;
    in_payload_length   <= r.len;
    in_pixel_x          <= r.x;
    in_pixel_y          <= r.y;
    do @(posedge clk); while (in_stall !== 1'b0);
    decode_request(r, exp_res);
    pending_results.insert(pending_results.size(), exp_res);
  endtask

  // Drop valid and wait before returning; n sets the length of the gap
  task automatic hold_off(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic request_t packet(input logic [2:0] code, input logic [63:0] lo,
                                      input logic [63:0] hi, input logic [4:0] len);
    request_t r;
    r.op     = OP_PACKET;
    r.code   = code;
    r.pay_lo = lo;
    r.pay_hi = hi;
    r.len    = len;
    r.x      = 9'($urandom);
    r.y      = 8'($urandom);
    return r;
  endfunction

  function automatic request_t pixel_read(input logic [8:0] x, input logic [7:0] y);
    request_t r;
    r = packet(3'($urandom), {$urandom, $urandom}, {$urandom, $urandom}, 5'($urandom));
    r.op = OP_READ;
    r.x  = x;
    r.y  = y;
    return r;
  endfunction

  // Mostly well-formed traffic: in-frame reads, tiles, palette and index loads and presets with
  // full payloads, plus short packets, off-frame tiles and reads, and ignored codes.
  function automatic request_t random_request(input bit preset_ok);
    request_t r;
    int       pick;
    r = packet(3'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
               ($urandom_range(0, 4) == 0) ? 5'($urandom) : PAYLOAD_FULL);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r.op = OP_READ;
      if (pick < 38) begin
        r.x = 9'($urandom_range(0, FRAME_W - 1));
        r.y = 8'($urandom_range(0, FRAME_H - 1));
      end
    end else if (pick < 75) begin
      r.code = INSTR_TILE;
      if (pick < 72) begin
        r.pay_lo[23:16] = {3'($urandom), 5'($urandom_range(0, TILE_ROWS_IN - 1))};
        r.pay_lo[31:24] = {2'($urandom), 6'($urandom_range(0, TILE_COLS_IN - 1))};
      end
    end else if (pick < 85) begin
      r.code = $urandom_range(0, 1) ? INSTR_CLUT_LOW : INSTR_CLUT_HIGH;
    end else if (pick < 93) begin
      r.code = $urandom_range(0, 1) ? INSTR_BORDER : INSTR_TRANSPARENT;
    end else if (pick < 97) begin
      r.code = $urandom_range(0, 1) ? INSTR_SPARE_6 : INSTR_SPARE_7;
    end else begin
      r.code = preset_ok ? INSTR_PRESET : INSTR_BORDER;
    end
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Result side: random stall bursts while enabled
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void log_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t ns: %s", $time, what);
  endfunction

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    pixel_result_t head;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        log_mismatch($sformatf("result %0d arrived with no request pending", results_seen));
      end else begin
        head = pending_results.pop_front();
        if (out_pixel_color !== head.color || out_border_index !== head.border ||
            out_transparent_index !== head.transp)
          log_mismatch($sformatf(
            "result %0d: expected color %06h border %h transp %h, got %06h %h %h",
            results_seen, head.color, head.border, head.transp,
            out_pixel_color, out_border_index, out_transparent_index));
      end
    end
  end

  // Stop a hung run: count cycles in which neither channel moves
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Palette and frame clear at reset, so every read returns black
  task automatic test_reset_state();
    send_request(pixel_read(9'd0, 8'd0));
    send_request(pixel_read(9'(FRAME_W - 1), 8'(FRAME_H - 1)));
  endtask

  // Load both palette halves, fill the frame, read inside and outside it
  task automatic test_palette_and_preset();
    logic [63:0] lo;
    send_request(packet(INSTR_CLUT_LOW, '1, '1, PAYLOAD_FULL));
    send_request(packet(INSTR_CLUT_HIGH, {$urandom, $urandom}, {$urandom, $urandom},
                        PAYLOAD_FULL));
    // upper nibble of the color byte must be dropped
    lo = {$urandom, $urandom};
    lo[7:0] = 8'h79;
    send_request(packet(INSTR_PRESET, lo, {$urandom, $urandom}, 5'd1));
    send_request(pixel_read(9'(FRAME_W - 1), 8'(FRAME_H - 1)));
    send_request(pixel_read(9'(FRAME_W), 8'd0));
    send_request(pixel_read(9'd0, 8'(FRAME_H)));
    send_request(pixel_read('1, '1));
  endtask

  // Border and transparent take the low nibble; a length above 16 counts as 16
  task automatic test_index_registers();
    send_request(packet(INSTR_BORDER, 64'h0123_4567_89AB_CDFB, '0, 5'd1));
    send_request(packet(INSTR_TRANSPARENT, 64'hFEDC_BA98_7654_32F4, '1, 5'd31));
  endtask

  // Short payloads change nothing, nor do the spare codes
  task automatic test_short_and_ignored();
    send_request(packet(INSTR_BORDER, '1, '1, 5'd0));
    send_request(packet(INSTR_TRANSPARENT, '1, '1, 5'd0));
    send_request(packet(INSTR_PRESET, '1, '1, 5'd0));
    send_request(packet(INSTR_TILE, '0, '1, 5'd15));
    send_request(packet(INSTR_CLUT_LOW, '0, '0, 5'd15));
    send_request(packet(INSTR_CLUT_HIGH, '0, '0, 5'd15));
    send_request(packet(INSTR_SPARE_6, '1, '1, PAYLOAD_FULL));
    send_request(packet(INSTR_SPARE_7, '1, '1, PAYLOAD_FULL));
  endtask

  // Last tile inside the bottom-right corner, then one entirely off the frame
  task automatic test_tile_edges();
    logic [63:0] lo;
    lo = {$urandom, $urandom};
    lo[31:16] = 16'hF1F1;  // row 17, column 49 once masked
    send_request(packet(INSTR_TILE, lo, {$urandom, $urandom}, PAYLOAD_FULL));
    lo = {$urandom, $urandom};
    lo[31:16] = 16'hFFFF;  // row 31, column 63: nothing lands
    send_request(packet(INSTR_TILE, lo, {$urandom, $urandom}, PAYLOAD_FULL));
    send_request(pixel_read(9'(FRAME_W - TILE_W), 8'(FRAME_H - TILE_H)));
    send_request(pixel_read(9'(FRAME_W - 1), 8'(FRAME_H - 1)));
  endtask

  // Random traffic with idle bursts on both sides; now and then pause the
  // sender until the decoder has returned everything.
  task automatic test_random_traffic();
    request_t r;
    int       presets_done;
    presets_done = 0;
    stall_on    = 1'b1;
    sender_gaps = 1'b1;
    drain_results();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = random_request(presets_done < RANDOM_PRESETS);
      if (r.op == OP_PACKET && r.code == INSTR_PRESET) presets_done++;
      send_request(r);
      if ($urandom_range(0, 199) == 0) drain_results();
      else if (sender_gaps && $urandom_range(0, 4) == 0) hold_off($urandom_range(1, 11));
      // alternate stretches with and without sender gaps
      if ($urandom_range(0, 99) == 0) sender_gaps = !sender_gaps;
    end
  endtask

  // Back-to-back requests with no idling on either side
  task automatic test_quiet_tail();
    stall_on    = 1'b0;
    sender_gaps = 1'b0;
    for (int n = 0; n < TAIL_ITEMS; n++) send_request(random_request(1'b0));
  endtask

  initial begin
    clear_shadow();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_palette_and_preset();
    test_index_registers();
    test_short_and_ignored();
    test_tile_edges();
    test_random_traffic();
    test_quiet_tail();

    // Wait out every result, then a margin to catch any stray one
    drain_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
